// ===== src/thermostat_alarm_supervisor_macros.svh =====
// Assertion macros shared by the thermostat alarm supervisor checkers.
// Each macro expects clk in scope; all but TAS_ASSERT_ALWAYS_NEXT also rst_n.
`ifndef THERMOSTAT_ALARM_SUPERVISOR_MACROS_SVH
`define THERMOSTAT_ALARM_SUPERVISOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TAS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define TAS_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tas_pkg.sv =====
// Package for the thermostat alarm supervisor: field widths, codes,
// register reset values and the configuration and result structs. No dependencies.
package tas_pkg;

  localparam int FUNC_W     = 2;
  localparam int TEMP_W     = 8;
  localparam int MODE_W     = 2;
  localparam int LIMIT_W    = 8;
  localparam int MS_W       = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;

  // Input item kinds.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_SAMPLE    = 2'd1,
    FUNC_ALARM_OFF = 2'd2
  } func_t;

  // Supervisor mode, coded as it appears on the result channel.
  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE  = 2'd0,
    MODE_HOT   = 2'd1,
    MODE_COLD  = 2'd2,
    MODE_ALARM = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER_LIMIT = 2'd0,
    REG_LOWER_LIMIT = 2'd1,
    REG_ALARM_DELAY = 2'd2,
    REG_OFF_HOLD    = 2'd3
  } reg_idx_t;

  localparam logic [LIMIT_W-1:0] UPPER_LIMIT_RST = 8'd30;
  localparam logic [LIMIT_W-1:0] LOWER_LIMIT_RST = 8'd15;
  localparam logic [MS_W-1:0]    ALARM_DELAY_RST = 17'd60000;
  localparam logic [MS_W-1:0]    OFF_HOLD_RST    = 17'd5000;

  typedef struct packed {
    logic [LIMIT_W-1:0] upper_limit;
    logic [LIMIT_W-1:0] lower_limit;
    logic [MS_W-1:0]    alarm_delay_ms;
    logic [MS_W-1:0]    alarm_off_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic  alarm_on;
    logic  heat_on;
    logic  cool_on;
    mode_t mode;
    logic  alarm_raised;
    logic  alarm_off_pending;
  } res_t;

endpackage

// ===== src/tas_if.sv =====
// Valid/ready channel interfaces for the thermostat alarm supervisor.
// Depends on tas_pkg for the field widths.
interface tas_in_if;
  logic                      valid;
  logic                      ready;
  logic [tas_pkg::FUNC_W-1:0] func;
  logic [tas_pkg::TEMP_W-1:0] temperature;

  modport source (output valid, func, temperature, input ready);
  modport sink   (input valid, func, temperature, output ready);
endinterface

interface tas_out_if;
  logic                      valid;
  logic                      ready;
  logic                      alarm_on;
  logic                      heat_on;
  logic                      cool_on;
  logic [tas_pkg::MODE_W-1:0] mode;
  logic                      alarm_raised;
  logic                      alarm_off_pending;

  modport source (output valid, alarm_on, heat_on, cool_on, mode, alarm_raised,
                  alarm_off_pending, input ready);
  modport sink   (input valid, alarm_on, heat_on, cool_on, mode, alarm_raised,
                  alarm_off_pending, output ready);
endinterface

// ===== src/tas_regs.sv =====
// Configuration register file of the thermostat alarm supervisor.
// Depends on tas_pkg for the register indexes, widths and reset values.
module tas_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            we,
  input  logic [tas_pkg::CFG_IDX_W-1:0]   index,
  input  logic [tas_pkg::CFG_DATA_W-1:0]  data,
  output tas_pkg::cfg_t                   cfg
);

  tas_pkg::cfg_t cfg_r;
  tas_pkg::cfg_t cfg_nxt;

  // Decode the write; each register keeps the low bits of the data.
  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      unique case (tas_pkg::reg_idx_t'(index))
        tas_pkg::REG_UPPER_LIMIT: cfg_nxt.upper_limit = data[tas_pkg::LIMIT_W-1:0];
        tas_pkg::REG_LOWER_LIMIT: cfg_nxt.lower_limit = data[tas_pkg::LIMIT_W-1:0];
        tas_pkg::REG_ALARM_DELAY: cfg_nxt.alarm_delay_ms = data[tas_pkg::MS_W-1:0];
        tas_pkg::REG_OFF_HOLD:    cfg_nxt.alarm_off_hold_ms = data[tas_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upper_limit       <= tas_pkg::UPPER_LIMIT_RST;
      cfg_r.lower_limit       <= tas_pkg::LOWER_LIMIT_RST;
      cfg_r.alarm_delay_ms    <= tas_pkg::ALARM_DELAY_RST;
      cfg_r.alarm_off_hold_ms <= tas_pkg::OFF_HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/tas_core.sv =====
// Supervisor state and rule logic: mode, millisecond counter, alarm-off flag
// and output pins, updated once per item. Depends on tas_pkg.
module tas_core #(
  parameter int COUNT_WIDTH = 17
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  tas_pkg::func_t               func,
  input  logic [tas_pkg::TEMP_W-1:0]   temperature,
  input  tas_pkg::cfg_t                cfg,
  output tas_pkg::res_t                res
);

  // Compare width covers both the counter and the millisecond registers.
  localparam int CMP_W = (COUNT_WIDTH > tas_pkg::MS_W) ? COUNT_WIDTH : tas_pkg::MS_W;

  tas_pkg::mode_t         mode_r, mode_nxt;
  logic [COUNT_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic                   flag_r, flag_nxt;
  logic                   alarm_r, alarm_nxt;
  logic                   heat_r, heat_nxt;
  logic                   cool_r, cool_nxt;
  logic                   raised;

  logic [CMP_W-1:0] elapsed_ext;
  logic             hold_hit;
  logic             delay_hit;
  logic             out_of_idle;
  logic             in_range;

  assign elapsed_ext = CMP_W'(elapsed_r);
  assign hold_hit    = elapsed_ext >= CMP_W'(cfg.alarm_off_hold_ms);
  assign delay_hit   = elapsed_ext >= CMP_W'(cfg.alarm_delay_ms);
  assign out_of_idle = (mode_r == tas_pkg::MODE_HOT) || (mode_r == tas_pkg::MODE_COLD);
  assign in_range    = (temperature >= cfg.lower_limit) && (temperature <= cfg.upper_limit);

  // Next state for the item at hand.
  always_comb begin
    mode_nxt    = mode_r;
    elapsed_nxt = elapsed_r;
    flag_nxt    = flag_r;
    alarm_nxt   = alarm_r;
    heat_nxt    = heat_r;
    cool_nxt    = cool_r;
    raised      = 1'b0;
    case (func)
      tas_pkg::FUNC_TICK: begin
        // The counter saturates at all ones.
        if (elapsed_r != {COUNT_WIDTH{1'b1}}) begin
          elapsed_nxt = elapsed_r + COUNT_WIDTH'(1);
        end
      end
      tas_pkg::FUNC_SAMPLE: begin
        // Alarm-off check: a pending request ends the alarm, else it may expire.
        if (flag_r && (mode_r == tas_pkg::MODE_ALARM)) begin
          alarm_nxt   = 1'b0;
          elapsed_nxt = '0;
          mode_nxt    = tas_pkg::MODE_IDLE;
        end else if (hold_hit) begin
          flag_nxt = 1'b0;
        end
        // Limit rules run only with no request pending; first match wins.
        // With the flag clear, mode and counter are still as they were.
        if (!flag_nxt) begin
          if (delay_hit && out_of_idle) begin
            mode_nxt  = tas_pkg::MODE_ALARM;
            alarm_nxt = 1'b1;
            raised    = 1'b1;
          end else if ((mode_r == tas_pkg::MODE_IDLE) && (temperature > cfg.upper_limit)) begin
            mode_nxt    = tas_pkg::MODE_HOT;
            elapsed_nxt = '0;
            heat_nxt    = 1'b1;
          end else if ((mode_r == tas_pkg::MODE_IDLE) && (temperature < cfg.lower_limit)) begin
            mode_nxt    = tas_pkg::MODE_COLD;
            elapsed_nxt = '0;
            cool_nxt    = 1'b1;
          end else if (in_range) begin
            elapsed_nxt = '0;
            flag_nxt    = (mode_r != tas_pkg::MODE_IDLE);
            mode_nxt    = tas_pkg::MODE_IDLE;
            heat_nxt    = 1'b0;
            cool_nxt    = 1'b0;
          end
        end
      end
      tas_pkg::FUNC_ALARM_OFF: begin
        flag_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // State advances only when the item moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= tas_pkg::MODE_IDLE;
      elapsed_r <= '0;
      flag_r    <= 1'b0;
      alarm_r   <= 1'b0;
      heat_r    <= 1'b0;
      cool_r    <= 1'b0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      flag_r    <= flag_nxt;
      alarm_r   <= alarm_nxt;
      heat_r    <= heat_nxt;
      cool_r    <= cool_nxt;
    end
  end

  // The result reports the state after this item.
  always_comb begin
    res.alarm_on          = alarm_nxt;
    res.heat_on           = heat_nxt;
    res.cool_on           = cool_nxt;
    res.mode              = mode_nxt;
    res.alarm_raised      = raised;
    res.alarm_off_pending = flag_nxt;
  end

endmodule

// ===== src/thermostat_alarm_supervisor.sv =====
// Top level of the thermostat alarm supervisor: input register, rule core,
// result register and configuration registers. Depends on tas_pkg, tas_if,
// tas_regs and tas_core.
//
// Usage:
//   in_if carries one item per beat: func (tick, sample or alarm-off request)
//   and temperature. out_if returns exactly one result beat per input beat,
//   in order, with the output levels, the mode, the alarm-raised pulse and
//   the pending alarm-off flag as they stand after that item.
//   An accepted beat is held in the input register, run through the rule
//   logic and captured in the result register, which drives out_if.
//   Throughput is one item per cycle while out_if is ready; the rule
//   logic is a few compares and a counter increment between the input and
//   result registers. When out_if stalls, the result register holds its beat
//   and the input register still takes one more beat; in_if.ready then
//   drops until the result is taken.
//   cfg_we writes cfg_data into the register at cfg_index;
//   write only while no item is in flight.
//   Synchronous reset (rst_n low) empties both registers, sets mode idle,
//   clears the counter, flag and pins, and loads the register defaults.
module thermostat_alarm_supervisor #(
  parameter int COUNT_WIDTH = 17
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tas_in_if.sink                         in_if,
  tas_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [tas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tas_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                       in_valid_r;
  tas_pkg::func_t             in_func_r;
  logic [tas_pkg::TEMP_W-1:0] in_temp_r;
  logic                       out_valid_r;
  tas_pkg::res_t              out_res_r;
  tas_pkg::res_t              core_res;
  tas_pkg::cfg_t              cfg;
  logic                       advance;
  logic                       in_beat;

  tas_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  tas_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .func        (in_func_r),
    .temperature (in_temp_r),
    .cfg         (cfg),
    .res         (core_res)
  );

  // The held item moves on whenever the result register is free or emptying.
  assign advance     = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || advance;
  assign in_beat     = in_if.valid && in_if.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_beat) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      in_func_r <= tas_pkg::func_t'(in_if.func);
      in_temp_r <= in_if.temperature;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.alarm_on          = out_res_r.alarm_on;
  assign out_if.heat_on           = out_res_r.heat_on;
  assign out_if.cool_on           = out_res_r.cool_on;
  assign out_if.mode              = out_res_r.mode;
  assign out_if.alarm_raised      = out_res_r.alarm_raised;
  assign out_if.alarm_off_pending = out_res_r.alarm_off_pending;

endmodule

// ===== src/tas_checker.sv =====
// Port-level checks for the thermostat alarm supervisor, bound to the top level.
// Depends on tas_pkg and the macros header.
`include "thermostat_alarm_supervisor_macros.svh"

module tas_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       alarm_on,
  input logic                       heat_on,
  input logic                       cool_on,
  input logic [tas_pkg::MODE_W-1:0] mode,
  input logic                       alarm_raised,
  input logic                       alarm_off_pending
);

  // No result beat is offered right after reset.
  `TAS_ASSERT_ALWAYS_NEXT(a_reset_empty, !rst_n, !out_valid, "result valid after reset")

  // A stalled result beat stays offered and unchanged.
  `TAS_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable({alarm_on, heat_on, cool_on, mode, alarm_raised, alarm_off_pending}), "stalled result changed")

  // Entering alarm drives the alarm pin and reports alarm mode.
  `TAS_ASSERT_SAME(a_raise_alarm, out_valid && alarm_raised, alarm_on && (mode == tas_pkg::MODE_ALARM), "alarm raised without alarm state")

  // The hot and cold modes always come with their output switched on.
  `TAS_ASSERT_SAME(a_mode_pins, out_valid && ((mode == tas_pkg::MODE_HOT) || (mode == tas_pkg::MODE_COLD)), (mode == tas_pkg::MODE_HOT) ? heat_on : cool_on, "mode without its output")

endmodule

bind thermostat_alarm_supervisor tas_checker u_tas_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .alarm_on          (out_if.alarm_on),
  .heat_on           (out_if.heat_on),
  .cool_on           (out_if.cool_on),
  .mode              (out_if.mode),
  .alarm_raised      (out_if.alarm_raised),
  .alarm_off_pending (out_if.alarm_off_pending)
);

// ===== bench/tb_thermostat_alarm_supervisor.sv =====
// Self-checking bench for the thermostat alarm supervisor: a scoreboard class
// predicts each result beat and compares it with the block's output.
// Depends on tas_pkg, tas_if and the thermostat_alarm_supervisor RTL.
module tb_thermostat_alarm_supervisor;

  localparam int COUNT_W = 17;
  localparam logic [tas_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Tracks the supervisor state and the result beats still owed by the block.
  class supervisor_scoreboard;
    logic [tas_pkg::LIMIT_W-1:0] upper_lim;
    logic [tas_pkg::LIMIT_W-1:0] lower_lim;
    logic [tas_pkg::MS_W-1:0]    delay_ms;
    logic [tas_pkg::MS_W-1:0]    hold_ms;
    tas_pkg::mode_t              cur_mode;
    logic [COUNT_W-1:0]          elapsed;
    bit                          off_req;
    bit                          alarm_pin;
    bit                          heat_pin;
    bit                          cool_pin;
    tas_pkg::res_t               levels_due[$];
    int                          errors;

    function new();
      upper_lim = tas_pkg::UPPER_LIMIT_RST;
      lower_lim = tas_pkg::LOWER_LIMIT_RST;
      delay_ms  = tas_pkg::ALARM_DELAY_RST;
      hold_ms   = tas_pkg::OFF_HOLD_RST;
      cur_mode  = tas_pkg::MODE_IDLE;
      elapsed   = '0;
      off_req   = 1'b0;
      alarm_pin = 1'b0;
      heat_pin  = 1'b0;
      cool_pin  = 1'b0;
      errors    = 0;
    endfunction

    // Mirrors a register write; limits keep only their low bits.
    function void write_reg(tas_pkg::reg_idx_t idx, logic [tas_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        tas_pkg::REG_UPPER_LIMIT: upper_lim = data[tas_pkg::LIMIT_W-1:0];
        tas_pkg::REG_LOWER_LIMIT: lower_lim = data[tas_pkg::LIMIT_W-1:0];
        tas_pkg::REG_ALARM_DELAY: delay_ms  = data[tas_pkg::MS_W-1:0];
        tas_pkg::REG_OFF_HOLD:    hold_ms   = data[tas_pkg::MS_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    // Runs one accepted input beat through the rules and queues its result.
    function void accept_item(logic [tas_pkg::FUNC_W-1:0] f, logic [tas_pkg::TEMP_W-1:0] t);
      bit            raised;
      tas_pkg::res_t due;
      raised = 1'b0;
      case (f)
        tas_pkg::FUNC_TICK: begin
          if (elapsed != '1) elapsed++;
        end
        tas_pkg::FUNC_SAMPLE: begin
          // An alarm-off request ends an alarm, or expires after the hold time.
          if (off_req && cur_mode == tas_pkg::MODE_ALARM) begin
            alarm_pin = 1'b0;
            elapsed   = '0;
            cur_mode  = tas_pkg::MODE_IDLE;
          end else if (elapsed >= hold_ms) begin
            off_req = 1'b0;
          end
          // Limit rules run only with no request pending; the first match wins.
          if (!off_req) begin
            if (elapsed >= delay_ms &&
                (cur_mode == tas_pkg::MODE_HOT || cur_mode == tas_pkg::MODE_COLD)) begin
              cur_mode  = tas_pkg::MODE_ALARM;
              alarm_pin = 1'b1;
              raised    = 1'b1;
            end else if (cur_mode == tas_pkg::MODE_IDLE && t > upper_lim) begin
              cur_mode = tas_pkg::MODE_HOT;
              elapsed  = '0;
              heat_pin = 1'b1;
            end else if (cur_mode == tas_pkg::MODE_IDLE && t < lower_lim) begin
              cur_mode = tas_pkg::MODE_COLD;
              elapsed  = '0;
              cool_pin = 1'b1;
            end else if (t >= lower_lim && t <= upper_lim) begin
              elapsed  = '0;
              off_req  = (cur_mode != tas_pkg::MODE_IDLE);
              cur_mode = tas_pkg::MODE_IDLE;
              heat_pin = 1'b0;
              cool_pin = 1'b0;
            end
          end
        end
        tas_pkg::FUNC_ALARM_OFF: begin
          off_req = 1'b1;
        end
        default: ;
      endcase
      due.alarm_on          = alarm_pin;
      due.heat_on           = heat_pin;
      due.cool_on           = cool_pin;
      due.mode              = cur_mode;
      due.alarm_raised      = raised;
      due.alarm_off_pending = off_req;
      levels_due.push_back(due);
    endfunction

    // Unknown bits on the block's side count as a mismatch.
    function void compare_field(string name, logic [tas_pkg::MODE_W-1:0] exp_val,
                                logic [tas_pkg::MODE_W-1:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    // Compares one result beat with the oldest expectation.
    function void check_levels(tas_pkg::res_t got);
      tas_pkg::res_t due;
      if (levels_due.size() == 0) begin
        $error("result beat arrived with no expectation waiting");
        errors++;
        return;
      end
      due = levels_due.pop_front();
      compare_field("alarm_on", due.alarm_on, got.alarm_on);
      compare_field("heat_on", due.heat_on, got.heat_on);
      compare_field("cool_on", due.cool_on, got.cool_on);
      compare_field("mode", due.mode, got.mode);
      compare_field("alarm_raised", due.alarm_raised, got.alarm_raised);
      compare_field("alarm_off_pending", due.alarm_off_pending, got.alarm_off_pending);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                           cfg_we;
  logic [tas_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tas_pkg::CFG_DATA_W-1:0] cfg_data;
  bit                             gaps_on = 1'b1;
  int                             beats_taken = 0;
  supervisor_scoreboard           levels;

  tas_in_if  in_ch();
  tas_out_if out_ch();

  thermostat_alarm_supervisor #(.COUNT_WIDTH(COUNT_W)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Offers one beat, with a random gap ahead of it, and waits for acceptance.
  task automatic send_item(logic [tas_pkg::FUNC_W-1:0] f, logic [tas_pkg::TEMP_W-1:0] t);
    while (gaps_on && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= f;
    in_ch.temperature <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    levels.accept_item(f, t);
  endtask

  // Stops offering beats and waits until every owed result has been taken.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (levels.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write.
  task automatic write_reg(tas_pkg::reg_idx_t idx, logic [tas_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    levels.write_reg(idx, data);
  endtask

  task automatic load_config(logic [tas_pkg::CFG_DATA_W-1:0] up,
                             logic [tas_pkg::CFG_DATA_W-1:0] lo,
                             logic [tas_pkg::CFG_DATA_W-1:0] dly,
                             logic [tas_pkg::CFG_DATA_W-1:0] hold);
    settle();
    write_reg(tas_pkg::REG_UPPER_LIMIT, up);
    write_reg(tas_pkg::REG_LOWER_LIMIT, lo);
    write_reg(tas_pkg::REG_ALARM_DELAY, dly);
    write_reg(tas_pkg::REG_OFF_HOLD, hold);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Temperatures cluster above, below and inside the current limits.
  function automatic logic [tas_pkg::TEMP_W-1:0] pick_temp();
    logic [tas_pkg::TEMP_W-1:0] up;
    logic [tas_pkg::TEMP_W-1:0] lo;
    up = levels.upper_lim;
    lo = levels.lower_lim;
    case ($urandom_range(3))
      0: return (up < 8'd255) ? 8'($urandom_range(255, up + 1)) : 8'd255;
      1: return (lo > 8'd0) ? 8'($urandom_range(lo - 1, 0)) : 8'd0;
      2: return (lo <= up) ? 8'($urandom_range(up, lo)) : 8'($urandom_range(255));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Random mix: mostly ticks and samples, some alarm-off requests and unused codes.
  task automatic run_mix(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        send_item(tas_pkg::FUNC_TICK, 8'($urandom_range(255)));
      end else if (r < 85) begin
        send_item(tas_pkg::FUNC_SAMPLE, pick_temp());
      end else if (r < 95) begin
        send_item(tas_pkg::FUNC_ALARM_OFF, 8'($urandom_range(255)));
      end else begin
        send_item(FUNC_UNUSED, 8'($urandom_range(255)));
      end
    end
  endtask

  // Result side: checks each beat, idles at random, and once holds off long.
  initial begin
    tas_pkg::res_t got;
    int            hold_left;
    bit            pressed;
    hold_left    = 0;
    pressed      = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.alarm_on          = out_ch.alarm_on;
        got.heat_on           = out_ch.heat_on;
        got.cool_on           = out_ch.cool_on;
        got.mode              = tas_pkg::mode_t'(out_ch.mode);
        got.alarm_raised      = out_ch.alarm_raised;
        got.alarm_off_pending = out_ch.alarm_off_pending;
        levels.check_levels(got);
        beats_taken++;
      end
      if (!pressed && beats_taken >= 600) begin
        pressed   = 1'b1;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(gaps_on && $urandom_range(99) < 13);
      end
    end
  end

  // Ends a hung run.
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    levels            = new();
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.func        = tas_pkg::FUNC_TICK;
    in_ch.temperature = '0;
    cfg_we            = 1'b0;
    cfg_index         = tas_pkg::REG_UPPER_LIMIT;
    cfg_data          = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at the reset limits: hot entry, far side, return in range
    // with a pending request, a tick, the unused code and a request.
    send_item(tas_pkg::FUNC_SAMPLE, 8'd255);
    send_item(tas_pkg::FUNC_SAMPLE, 8'd0);
    send_item(tas_pkg::FUNC_SAMPLE, 8'd20);
    send_item(tas_pkg::FUNC_SAMPLE, 8'd0);
    send_item(tas_pkg::FUNC_TICK, 8'hAA);
    send_item(FUNC_UNUSED, 8'h55);
    send_item(tas_pkg::FUNC_ALARM_OFF, 8'd0);

    // Limits written with upper bits set to check masking; short delay and hold.
    load_config(17'h1FF28, 17'h1FF0A, 17'd2, 17'd1);
    send_item(tas_pkg::FUNC_SAMPLE, 8'd10);
    send_item(tas_pkg::FUNC_SAMPLE, 8'd41);
    send_item(tas_pkg::FUNC_TICK, 8'd0);
    send_item(tas_pkg::FUNC_SAMPLE, 8'd41);
    send_item(tas_pkg::FUNC_TICK, 8'd0);
    send_item(tas_pkg::FUNC_SAMPLE, 8'd41);
    // Back in range while in alarm: the alarm level stays on in idle.
    send_item(tas_pkg::FUNC_SAMPLE, 8'd20);
    send_item(tas_pkg::FUNC_SAMPLE, 8'd9);
    send_item(tas_pkg::FUNC_TICK, 8'd0);
    send_item(tas_pkg::FUNC_SAMPLE, 8'd9);
    send_item(tas_pkg::FUNC_TICK, 8'd0);
    send_item(tas_pkg::FUNC_TICK, 8'd0);
    send_item(tas_pkg::FUNC_SAMPLE, 8'd0);
    send_item(tas_pkg::FUNC_ALARM_OFF, 8'd0);
    send_item(tas_pkg::FUNC_SAMPLE, 8'd25);
    send_item(tas_pkg::FUNC_SAMPLE, 8'd40);

    // Random phases over several register settings, extremes included.
    for (int p = 0; p < 8; p++) begin
      logic [tas_pkg::CFG_DATA_W-1:0] lo;
      case (p)
        0: load_config(17'd255, 17'd0, 17'd0, 17'd0);
        1: load_config(17'd0, 17'd255, 17'd1, 17'h1FFFF);
        2: load_config(17'd0, 17'd0, 17'd0, 17'd3);
        default: begin
          lo = 17'($urandom_range(200));
          load_config(17'(lo + $urandom_range(55)), lo, 17'($urandom_range(20, 1)),
                      17'($urandom_range(30, 1)));
        end
      endcase
      gaps_on = (p != 3);
      run_mix(226);
    end
    gaps_on = 1'b1;

    // Delay at the counter maximum: a short run of ticks keeps the hot mode
    // without raising the alarm.
    load_config(17'd100, 17'd50, 17'h1FFFF, 17'h1FFFF);
    send_item(tas_pkg::FUNC_SAMPLE, 8'd200);
    repeat (20) send_item(tas_pkg::FUNC_TICK, 8'd0);
    send_item(tas_pkg::FUNC_SAMPLE, 8'd200);
    send_item(tas_pkg::FUNC_SAMPLE, 8'd75);

    settle();
    if (levels.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
